// ===== hdl/roman_numeral_encoder_assert.svh =====
// Assertion macros for the roman numeral encoder checker.
`ifndef ROMAN_NUMERAL_ENCODER_ASSERT_SVH
`define ROMAN_NUMERAL_ENCODER_ASSERT_SVH

// Holds at every clock edge outside reset.
`define RNE_ASSERT_NOW(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) \
    else $error("rne check failed");

// If pre holds at one edge, post holds at the next.
`define RNE_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error("rne check failed");

`endif

// ===== hdl/rne_pkg.sv =====
package rne_pkg;

  localparam int unsigned NumTerms    = 13;
  localparam int unsigned MidDepthDef = 2;
  localparam int unsigned OutDepthDef = 2;

  typedef logic [11:0] value_t;
  typedef logic [7:0]  symbol_t;
  typedef logic [1:0]  status_t;
  typedef logic [3:0]  term_t;

  localparam value_t ValueMax = 12'd3999;

  localparam status_t STATUS_OK    = 2'd0;
  localparam status_t STATUS_ZERO  = 2'd1;
  localparam status_t STATUS_RANGE = 2'd2;

  localparam symbol_t CH_NONE = 8'h00;
  localparam symbol_t CH_I    = 8'h49;
  localparam symbol_t CH_V    = 8'h56;
  localparam symbol_t CH_X    = 8'h58;
  localparam symbol_t CH_L    = 8'h4C;
  localparam symbol_t CH_C    = 8'h43;
  localparam symbol_t CH_D    = 8'h44;
  localparam symbol_t CH_M    = 8'h4D;

  // Greedy terms, largest first
  localparam value_t Weight [NumTerms] = '{
    12'd1000, 12'd900, 12'd500, 12'd400, 12'd100, 12'd90, 12'd50,
    12'd40, 12'd10, 12'd9, 12'd5, 12'd4, 12'd1
  };
  localparam symbol_t Glyph1 [NumTerms] = '{
    CH_M, CH_C, CH_D, CH_C, CH_C, CH_X, CH_L, CH_X, CH_X, CH_I, CH_V, CH_I, CH_I
  };
  // CH_NONE: single-letter symbol
  localparam symbol_t Glyph2 [NumTerms] = '{
    CH_NONE, CH_M, CH_NONE, CH_D, CH_NONE, CH_C, CH_NONE, CH_L, CH_NONE,
    CH_X, CH_NONE, CH_V, CH_NONE
  };

  typedef enum logic [1:0] {
    KIND_OK,
    KIND_ZERO,
    KIND_RANGE
  } kind_e;

  typedef struct packed {
    value_t value;
    kind_e  kind;
  } job_t;

  typedef struct packed {
    symbol_t symbol;
    logic    last;
    status_t status;
  } res_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_EMIT,
    BK_TAIL,
    BK_FLAG
  } back_state_e;

endpackage

// ===== hdl/roman_numeral_encoder.sv =====
// Roman numeral encoder: one 12-bit number in, its Roman numeral out as a
// stream of ASCII letters, one word per letter, last letter flagged.
// Input channel: push_i / full_o, word accepted when push_i && !full_o.
// Output channel: empty_o / pop_i, oldest letter shown while !empty_o and
// taken when pop_i && !empty_o; symbol_o, last_o and status_o go together.
// 1..3999 encode greedily (M, CM, D, ... IV, I); zero gives one word with
// status 1, 4000..4095 one word with status 2, both with symbol 0, last 1.
// The first letter passes the middle queue, the sequencer's load state and
// the output queue before it shows. The back sequencer loads a number, then
// emits its letters in turn, and takes the next number only after the last.
// A short queue sits between classifier and sequencer, and an output queue
// holds finished letters, so input is still taken while the reader stalls;
// a stalled reader fills the output queue, then the sequencer holds, then
// the middle queue fills and full_o rises. Nothing is lost or repeated.
// Reset (rst_ni low, asynchronous) empties both queues and idles the
// sequencer; no state survives from one number to the next.
module roman_numeral_encoder #(
  parameter int unsigned MidDepth = rne_pkg::MidDepthDef,
  parameter int unsigned OutDepth = rne_pkg::OutDepthDef
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  output logic             full_o,
  input  rne_pkg::value_t  value_i,
  output logic             empty_o,
  input  logic             pop_i,
  output rne_pkg::symbol_t symbol_o,
  output logic             last_o,
  output rne_pkg::status_t status_o
);

  import rne_pkg::*;

  // front -> middle queue
  logic mid_push, mid_full, mid_pop, mid_empty;
  job_t mid_job_in, mid_job_out;

  // back -> output queue
  logic out_push, out_full;
  res_t out_res_in, out_res_out;

  rne_front u_front (
    .push_i   (push_i),
    .value_i  (value_i),
    .full_o   (full_o),
    .q_push_o (mid_push),
    .q_job_o  (mid_job_in),
    .q_full_i (mid_full)
  );

  rne_fifo #(
    .Width ($bits(job_t)),
    .Depth (MidDepth)
  ) u_mid_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (mid_push),
    .data_i  (mid_job_in),
    .full_o  (mid_full),
    .pop_i   (mid_pop),
    .data_o  (mid_job_out),
    .empty_o (mid_empty)
  );

  rne_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_empty_i  (mid_empty),
    .q_job_i    (mid_job_out),
    .q_pop_o    (mid_pop),
    .out_full_i (out_full),
    .out_push_o (out_push),
    .out_res_o  (out_res_in)
  );

  // Output queue decouples the sequencer from a stalling reader
  rne_fifo #(
    .Width ($bits(res_t)),
    .Depth (OutDepth)
  ) u_out_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (out_push),
    .data_i  (out_res_in),
    .full_o  (out_full),
    .pop_i   (pop_i),
    .data_o  (out_res_out),
    .empty_o (empty_o)
  );

  assign symbol_o = out_res_out.symbol;
  assign last_o   = out_res_out.last;
  assign status_o = out_res_out.status;

endmodule

// ===== hdl/rne_fifo.sv =====
module rne_fifo #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [Width-1:0] data_o,
  output logic             empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

// ===== hdl/rne_front.sv =====
module rne_front (
  input  logic            push_i,
  input  rne_pkg::value_t value_i,
  output logic            full_o,
  output logic            q_push_o,
  output rne_pkg::job_t   q_job_o,
  input  logic            q_full_i
);

  import rne_pkg::*;

  assign full_o          = q_full_i;
  assign q_push_o        = push_i;

  always_comb begin
    q_job_o.value = value_i;
    if (value_i == '0) begin
      q_job_o.kind = KIND_ZERO;
    end else if (value_i > ValueMax) begin
      q_job_o.kind = KIND_RANGE;
    end else begin
      q_job_o.kind = KIND_OK;
    end
  end

endmodule

// ===== hdl/rne_back.sv =====
module rne_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          q_empty_i,
  input  rne_pkg::job_t q_job_i,
  output logic          q_pop_o,
  input  logic          out_full_i,
  output logic          out_push_o,
  output rne_pkg::res_t out_res_o
);

  import rne_pkg::*;

  back_state_e state_q, state_d;
  value_t      rest_q, rest_next;
  symbol_t     tail_q;
  status_t     flag_q;
  term_t       sel;

  // Largest term that still fits; lowest index wins
  always_comb begin
    sel = '0;
    for (int t = NumTerms - 1; t >= 0; t--) begin
      if (rest_q >= Weight[t]) begin
        sel = term_t'(t);
      end
    end
  end

  assign rest_next = rest_q - Weight[sel];

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      BK_IDLE: begin
        if (!q_empty_i) begin
          state_d = (q_job_i.kind == KIND_OK) ? BK_EMIT : BK_FLAG;
        end
      end
      BK_EMIT: begin
        if (!out_full_i) begin
          if (Glyph2[sel] != CH_NONE) begin
            state_d = BK_TAIL;
          end else if (rest_next == '0) begin
            state_d = BK_IDLE;
          end
        end
      end
      BK_TAIL: begin
        if (!out_full_i) begin
          state_d = (rest_q == '0) ? BK_IDLE : BK_EMIT;
        end
      end
      BK_FLAG: begin
        if (!out_full_i) begin
          state_d = BK_IDLE;
        end
      end
      default: state_d = BK_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    q_pop_o    = 1'b0;
    out_push_o = 1'b0;
    out_res_o  = '{symbol: CH_NONE, last: 1'b0, status: STATUS_OK};
    case (state_q)
      BK_IDLE: begin
        q_pop_o = !q_empty_i;
      end
      BK_EMIT: begin
        out_push_o       = !out_full_i;
        out_res_o.symbol = Glyph1[sel];
        out_res_o.last   = (Glyph2[sel] == CH_NONE) && (rest_next == '0);
      end
      BK_TAIL: begin
        out_push_o       = !out_full_i;
        out_res_o.symbol = tail_q;
        out_res_o.last   = (rest_q == '0);
      end
      BK_FLAG: begin
        out_push_o       = !out_full_i;
        out_res_o.last   = 1'b1;
        out_res_o.status = flag_q;
      end
      default: begin
        q_pop_o = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BK_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      rest_q <= q_job_i.value;
      flag_q <= (q_job_i.kind == KIND_ZERO) ? STATUS_ZERO : STATUS_RANGE;
    end else if ((state_q == BK_EMIT) && out_push_o) begin
      rest_q <= rest_next;
      tail_q <= Glyph2[sel];
    end
  end

endmodule

// ===== hdl/rne_checker.sv =====
`include "roman_numeral_encoder_assert.svh"

module rne_checker (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             empty_o,
  input logic             pop_i,
  input rne_pkg::symbol_t symbol_o,
  input logic             last_o,
  input rne_pkg::status_t status_o
);

  import rne_pkg::*;

  // Flag words carry no letter and close their run
  `RNE_ASSERT_NOW(a_flag_word,
    empty_o || status_o == STATUS_OK || (symbol_o == CH_NONE && last_o))
  // Only the three status codes appear
  `RNE_ASSERT_NOW(a_status_code,
    empty_o || status_o == STATUS_OK || status_o == STATUS_ZERO ||
    status_o == STATUS_RANGE)
  // Good words hold a numeral letter
  `RNE_ASSERT_NOW(a_letter,
    empty_o || status_o != STATUS_OK || symbol_o == CH_I || symbol_o == CH_V ||
    symbol_o == CH_X || symbol_o == CH_L || symbol_o == CH_C || symbol_o == CH_D ||
    symbol_o == CH_M)
  // A waiting word holds while the reader stalls
  `RNE_ASSERT_NEXT(a_hold, !empty_o && !pop_i,
    !empty_o && $stable(symbol_o) && $stable(last_o) && $stable(status_o))

endmodule

bind roman_numeral_encoder rne_checker u_rne_checker (.*);

// ===== dv/roman_numeral_encoder_test.sv =====
`timescale 1ns / 100ps

// Checks the Roman numeral encoder: numbers go in through the push/full side,
// letters come back one word each through the empty/pop side. Every letter is
// compared field by field with a predicted stream built when the number was
// taken. Both sides pause at random so back pressure lands on every phase.
module roman_numeral_encoder_test;
  import rne_pkg::*;

  // Cycles with no word moving on either side before the run is declared hung.
  // The worst honest gap is the longest random pause plus the trip through the pipeline.
  localparam int StallLimit  = 2000;
  // Quiet period after the last letter, to catch stray trailing words.
  localparam int DrainCycles = 24;

  typedef struct {
    symbol_t symbol;
    logic    last;
    status_t status;
  } letter_t;

  logic    clk_i  = 1'b0;
  logic    rst_ni = 1'b0;
  logic    push   = 1'b0;
  value_t  value  = '0;
  logic    pop    = 1'b0;
  logic    full;
  logic    empty;
  symbol_t symbol;
  logic    last;
  status_t status;

  // Letters still owed by the block, oldest first.
  letter_t letters_due [$];
  int      mismatches  = 0;
  int      idle_cycles = 0;
  // When set, the matching side runs flat out with no pauses.
  bit      feed_steady  = 1'b0;
  bit      drain_steady = 1'b0;

  // Greedy terms, largest first; two-letter terms give two words.
  int    term_weight [13] = '{1000, 900, 500, 400, 100, 90, 50, 40, 10, 9, 5, 4, 1};
  string term_glyph  [13] = '{"M", "CM", "D", "CD", "C", "XC", "L", "XL", "X",
                              "IX", "V", "IV", "I"};

  roman_numeral_encoder u_dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .full_o   (full),
    .value_i  (value),
    .empty_o  (empty),
    .pop_i    (pop),
    .symbol_o (symbol),
    .last_o   (last),
    .status_o (status)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Appends the letters that one number should produce.
  function automatic void encode_numeral(value_t v);
    int      rest;
    string   glyph;
    letter_t w;
    w.last   = 1'b1;
    w.symbol = CH_NONE;
    if (v == '0) begin
      // zero: a single flag word, no letters
      w.status = STATUS_ZERO;
      letters_due.push_back(w);
      return;
    end
    if (v > ValueMax) begin
      // out of range: one flag word, never extra M's
      w.status = STATUS_RANGE;
      letters_due.push_back(w);
      return;
    end
    rest     = int'(v);
    w.last   = 1'b0;
    w.status = STATUS_OK;
    for (int t = 0; t < 13; t++) begin
      while (rest >= term_weight[t]) begin
        rest  -= term_weight[t];
        glyph  = term_glyph[t];
        for (int i = 0; i < glyph.len(); i++) begin
          w.symbol = symbol_t'(glyph[i]);
          letters_due.push_back(w);
        end
      end
    end
    letters_due[letters_due.size() - 1].last = 1'b1;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("[%0t] mismatch on %s: got 0x%0h, expected 0x%0h", $realtime, what, got, want);
    mismatches++;
  endtask

  // Offers one number after a random pause and holds it until taken.
  // push stays high across back-to-back words, so it is never lowered and
  // raised in the same step.
  task automatic send_value(value_t v);
    int gap;
    gap = feed_steady ? 0 : $urandom_range(0, 17);
    if (gap != 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    push  <= 1'b1;
    value <= v;
    do @(posedge clk_i); while (full);
    encode_numeral(v);
  endtask

  // Zero, one, the top of the range, the flagged band above it, the longest
  // numeral, the single high bit 2048 and 3000.
  task automatic test_extremes;
    value_t edge_values [$];
    edge_values = '{12'd0, 12'd1, 12'd3999, 12'd4000, 12'd4095, 12'd3888,
                    12'd2048, 12'd3000};
    foreach (edge_values[i]) send_value(edge_values[i]);
  endtask

  // Every term on its own, subtractive pairs included, then a few mixes.
  task automatic test_each_term;
    foreach (term_weight[t]) send_value(value_t'(term_weight[t]));
    send_value(12'd1994);
    send_value(12'd3444);
    send_value(12'd2999);
  endtask

  // Mostly well-formed numbers, with zero and out-of-range flags mixed in.
  // Runs in chunks so that some stretches have no pauses on one side or both.
  task automatic test_random_numbers;
    int     pick;
    value_t v;
    for (int chunk = 0; chunk < 9; chunk++) begin
      feed_steady  = ($urandom_range(0, 3) == 0);
      drain_steady = ($urandom_range(0, 3) == 0);
      for (int n = 0; n < 10; n++) begin
        pick = $urandom_range(0, 19);
        if (pick == 0)      v = '0;
        else if (pick == 1) v = value_t'($urandom_range(4000, 4095));
        else if (pick == 2) v = value_t'($urandom_range(0, 4095));
        else                v = value_t'($urandom_range(1, 3999));
        send_value(v);
      end
    end
    feed_steady  = 1'b0;
    drain_steady = 1'b0;
  endtask

  // Reader: pauses a random number of cycles per letter, then pops until one
  // is taken.
  initial begin
    int stall;
    wait (rst_ni);
    forever begin
      stall = drain_steady ? 0 : $urandom_range(0, 17);
      if (stall != 0) begin
        pop <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      pop <= 1'b1;
      do @(posedge clk_i); while (empty);
    end
  end

  // Checker: values read here are those the edge itself sampled.
  always @(posedge clk_i) begin
    letter_t want;
    if (rst_ni && pop && !empty) begin
      if (letters_due.size() == 0) begin
        report_mismatch("unexpected word", int'(symbol), 0);
      end else begin
        want = letters_due.pop_front();
        if (symbol !== want.symbol) report_mismatch("symbol", int'(symbol), int'(want.symbol));
        if (last !== want.last)     report_mismatch("last", int'(last), int'(want.last));
        if (status !== want.status) report_mismatch("status", int'(status), int'(want.status));
      end
    end
  end

  // Watchdog: any word moving on either side resets the count.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((push && !full) || (pop && !empty)) idle_cycles = 0;
      else                                    idle_cycles++;
      if (idle_cycles >= StallLimit) begin
        $display("roman_numeral_encoder_test NOT OK");
        $finish;
      end
    end
  end

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_extremes();
    test_each_term();
    test_random_numbers();
    push <= 1'b0;
    // wait for the last letters, then watch for strays
    while (letters_due.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("roman_numeral_encoder_test OK");
    end else begin
      $display("roman_numeral_encoder_test NOT OK");
    end
    $finish;
  end

endmodule
